### hdl/rcfd_pkg.sv
// Shared types and constants of the serial RC frame decoder.
`timescale 1ns / 1ps
package rcfd_pkg;

   // Frame geometry defaults.
   localparam int FRAME_BYTES_DEF  = 69;
   localparam int MAX_CHANNELS_DEF = 16;

   // Start bytes, failsafe marker and mode B frame layout.
   localparam logic [7:0] MODEB_START  = 8'hA1;
   localparam logic [7:0] MODEA_START  = 8'hA4;
   localparam logic [7:0] FAILSAFE_HI  = 8'h80;
   localparam int         MODEB_LEN    = 27;
   localparam int         MODEB_MAX_CH = 12;
   localparam int         MODEB_CRC_HI = 25;

   // Check polynomials.
   localparam logic [15:0] CRC16_POLY = 16'h1021;
   localparam logic [7:0]  CRC8_POLY  = 8'h8C;

   // Pulse conversion.
   localparam logic [10:0] PULSE_SCALE = 11'd1400;
   localparam logic [14:0] PULSE_BASE  = 15'd800;
   localparam int          ACC_W       = 27;

   // Field widths.
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;
   localparam int STATUS_W   = 3;
   localparam int CHANNEL_W  = 4;
   localparam int PULSE_W    = 15;

   // Configuration register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_MODE  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_GAP   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_CHANS = 2'd2;

   // Reset values of the configuration registers.
   localparam logic [15:0] GAP_LIMIT_RST = 16'd8000;
   localparam logic [3:0]  CHANS_RST     = 4'd12;

   // Result status codes.
   localparam logic [STATUS_W-1:0] STAT_UPDATE   = 3'd0;
   localparam logic [STATUS_W-1:0] STAT_NO_UPD   = 3'd1;
   localparam logic [STATUS_W-1:0] STAT_CRC_ERR  = 3'd2;
   localparam logic [STATUS_W-1:0] STAT_FAILSAFE = 3'd3;
   localparam logic [STATUS_W-1:0] STAT_BAD_LEN  = 3'd4;

   // Decoder sequencer states.
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CRC,
      ST_BAD,
      ST_CHECK,
      ST_READ,
      ST_MUL,
      ST_CAND,
      ST_FLUSH
   } state_type;

   // Control of the bit-serial check unit.
   typedef struct packed {
      logic clear;
      logic load;
      logic shift;
      logic mode_a;
   } crc_ctrl_type;

   // Control of the shift-add multiplier.
   typedef struct packed {
      logic load;
      logic step;
   } mul_ctrl_type;

endpackage

### hdl/rcfd_req_if.sv
// Input byte channel of the frame decoder.
`timescale 1ns / 1ps
interface rcfd_req_if;
   logic        valid;
   logic        ready;
   logic [7:0]  byte_in;
   logic [15:0] gap_us;

   modport source (output valid, output byte_in, output gap_us, input ready);
   modport sink (input valid, input byte_in, input gap_us, output ready);
endinterface

### hdl/rcfd_rsp_if.sv
// Result channel of the frame decoder.
`timescale 1ns / 1ps
interface rcfd_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  status;
   logic [3:0]  channel;
   logic [14:0] pulse_us;
   logic        last;

   modport source (output valid, output status, output channel, output pulse_us,
                   output last, input ready);
   modport sink (input valid, input status, input channel, input pulse_us,
                 input last, output ready);
endinterface

### hdl/rcfd_crc_serial.sv
// Bit-serial CRC-16 and reflected CRC-8 over received bytes.
`timescale 1ns / 1ps
module rcfd_crc_serial import rcfd_pkg::*; (
   input  logic         clock,
   input  crc_ctrl_type ctrl,
   input  logic [7:0]   data,
   output logic [15:0]  crc16,
   output logic [7:0]   crc8
);
   logic [7:0]  data_ff, data_in;
   logic [15:0] crc16_ff, crc16_in;
   logic [7:0]  crc8_ff, crc8_in;
   logic        fb16, fb8;

   // One data bit per cycle while shift is set: MSB first for CRC-16, LSB first for CRC-8.
   always_comb begin
      data_in  = data_ff;
      crc16_in = crc16_ff;
      crc8_in  = crc8_ff;
      fb16     = crc16_ff[15] ^ data_ff[7];
      fb8      = crc8_ff[0] ^ data_ff[0];
      if (ctrl.load) begin
         data_in = data;
         if (ctrl.clear) begin
            crc16_in = '0;
            crc8_in  = '0;
         end
      end else if (ctrl.shift) begin
         if (ctrl.mode_a) begin
            crc8_in = {1'b0, crc8_ff[7:1]} ^ (fb8 ? CRC8_POLY : 8'h00);
            data_in = {1'b0, data_ff[7:1]};
         end else begin
            crc16_in = {crc16_ff[14:0], 1'b0} ^ (fb16 ? CRC16_POLY : 16'h0000);
            data_in  = {data_ff[6:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      data_ff  <= data_in;
      crc16_ff <= crc16_in;
      crc8_ff  <= crc8_in;
   end

   assign crc16 = crc16_ff;
   assign crc8  = crc8_ff;
endmodule

### hdl/rcfd_mul_serial.sv
// Shift-add multiplier of a 16-bit channel value by the pulse scale.
`timescale 1ns / 1ps
module rcfd_mul_serial import rcfd_pkg::*; (
   input  logic             clock,
   input  mul_ctrl_type     ctrl,
   input  logic [15:0]      value,
   output logic [ACC_W-1:0] product
);
   logic [15:0]      val_ff, val_in;
   logic [ACC_W-1:0] acc_ff, acc_in;

   // One multiplier bit per step, most significant first.
   always_comb begin
      val_in = val_ff;
      acc_in = acc_ff;
      if (ctrl.load) begin
         val_in = value;
         acc_in = '0;
      end else if (ctrl.step) begin
         val_in = {val_ff[14:0], 1'b0};
         acc_in = {acc_ff[ACC_W-2:0], 1'b0}
                + (val_ff[15] ? ACC_W'(PULSE_SCALE) : ACC_W'(0));
      end
   end

   always_ff @(posedge clock) begin
      val_ff <= val_in;
      acc_ff <= acc_in;
   end

   assign product = acc_ff;
endmodule

### hdl/rc_serial_frame_decoder.sv
// Top level of the serial RC frame decoder: framing, frame store and result sequencer.
`timescale 1ns / 1ps
// Each byte accepted inside a frame is written to the frame store and then,
// if the check covers it, folded into the running check value one bit per
// cycle; no new byte is accepted until that check-unit pass ends. At frame end
// the sequencer checks the CRC (and in mode A the failsafe flag), then walks
// the channel entries: each entry reads its bytes from the frame store one per
// cycle and runs a 16-step shift-add multiply, and the final result is then
// flushed. No byte is accepted while a frame is being unpacked.
// Results wait in an output register, one item at a time.
module rc_serial_frame_decoder import rcfd_pkg::*; #(
   parameter int FRAME_BYTES  = FRAME_BYTES_DEF,
   parameter int MAX_CHANNELS = MAX_CHANNELS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   rcfd_req_if.sink              req_chan,
   rcfd_rsp_if.source            rsp_chan,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);
   localparam int AW      = $clog2(FRAME_BYTES);
   localparam int PW      = $clog2(FRAME_BYTES + 1);
   localparam int ENT_A   = (FRAME_BYTES - 5) / 4;
   localparam int MAX_ENT = (ENT_A > MODEB_MAX_CH) ? ENT_A : MODEB_MAX_CH;
   localparam int EW      = $clog2(MAX_ENT + 1);
   localparam int KW      = $clog2(MAX_CHANNELS + 1);

   // Frame store.
   logic [7:0] mem [FRAME_BYTES];
   logic [7:0] mem_q_ff;
   logic       mem_we;
   logic [AW-1:0] mem_waddr, mem_raddr;

   state_type state_ff, state_in;
   logic              mode_ff, mode_in;
   logic [15:0]       gap_lim_ff, gap_lim_in;
   logic [3:0]        chans_ff, chans_in;
   logic [PW-1:0]     pos_ff, pos_in;
   logic [PW-1:0]     exp_ff, exp_in;
   logic              recv_ff, recv_in;
   logic [7:0]        b2_ff, b2_in, b3_ff, b3_in, b25_ff, b25_in;
   logic [7:0]        lastb_ff, lastb_in, len_ff, len_in;
   logic              incl_ff, incl_in, fend_ff, fend_in;
   logic [2:0]        bit_cnt_ff, bit_cnt_in;
   logic [EW-1:0]     n_ff, n_in, ent_ff, ent_in;
   logic [KW-1:0]     k_ff, k_in;
   logic [PW-1:0]     base_ff, base_in;
   logic [2:0]        rd_cnt_ff, rd_cnt_in;
   logic [31:0]       word_ff, word_in;
   logic [3:0]        mul_cnt_ff, mul_cnt_in;
   logic              pend_v_ff, pend_v_in;
   logic [CHANNEL_W-1:0] pend_ch_ff, pend_ch_in;
   logic [PULSE_W-1:0]   pend_pw_ff, pend_pw_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0]  rsp_status_ff, rsp_status_in;
   logic [CHANNEL_W-1:0] rsp_ch_ff, rsp_ch_in;
   logic [PULSE_W-1:0]   rsp_pw_ff, rsp_pw_in;
   logic                 rsp_last_ff, rsp_last_in;

   crc_ctrl_type      crc_ctrl;
   mul_ctrl_type      mul_ctrl;
   logic [15:0]       crc16;
   logic [7:0]        crc8;
   logic [ACC_W-1:0]  product;

   // Combinational helpers.
   logic              out_free, out_load;
   logic              gap_hit, recv0, start_hit, recv1, len_bad, fend, crc_ok;
   logic [PW-1:0]     pos0, exp1, exp2;
   logic [PW:0]       pos1;
   logic [2:0]        nbytes;
   logic [7:0]        cand_num, cand_fn;
   logic              cand_ok, ent_done;
   logic [KW-1:0]     k_next;
   logic [PULSE_W-1:0]   cand_pw;
   logic [CHANNEL_W-1:0] cand_ch;
   logic [7:0]        len_m2;

   rcfd_crc_serial u_crc (
      .clock (clock),
      .ctrl  (crc_ctrl),
      .data  (req_chan.byte_in),
      .crc16 (crc16),
      .crc8  (crc8)
   );

   rcfd_mul_serial u_mul (
      .clock   (clock),
      .ctrl    (mul_ctrl),
      .value   ({word_ff[7:0], mem_q_ff}),
      .product (product)
   );

   // Frame store write and registered read.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= req_chan.byte_in;
      end
      mem_q_ff <= mem[mem_raddr];
   end

   assign req_chan.ready    = (state_ff == ST_IDLE);
   assign rsp_chan.valid    = rsp_valid_ff;
   assign rsp_chan.status   = rsp_status_ff;
   assign rsp_chan.channel  = rsp_ch_ff;
   assign rsp_chan.pulse_us = rsp_pw_ff;
   assign rsp_chan.last     = rsp_last_ff;

   // Framing, sequencing and result generation.
   always_comb begin
      state_in     = state_ff;
      mode_in      = mode_ff;
      gap_lim_in   = gap_lim_ff;
      chans_in     = chans_ff;
      pos_in       = pos_ff;
      exp_in       = exp_ff;
      recv_in      = recv_ff;
      b2_in        = b2_ff;
      b3_in        = b3_ff;
      b25_in       = b25_ff;
      lastb_in     = lastb_ff;
      len_in       = len_ff;
      incl_in      = incl_ff;
      fend_in      = fend_ff;
      bit_cnt_in   = bit_cnt_ff;
      n_in         = n_ff;
      ent_in       = ent_ff;
      k_in         = k_ff;
      base_in      = base_ff;
      rd_cnt_in    = rd_cnt_ff;
      word_in      = word_ff;
      mul_cnt_in   = mul_cnt_ff;
      pend_v_in    = pend_v_ff;
      pend_ch_in   = pend_ch_ff;
      pend_pw_in   = pend_pw_ff;
      rsp_status_in = rsp_status_ff;
      rsp_ch_in    = rsp_ch_ff;
      rsp_pw_in    = rsp_pw_ff;
      rsp_last_in  = rsp_last_ff;
      out_load     = 1'b0;
      crc_ctrl     = '{clear: 1'b0, load: 1'b0, shift: 1'b0, mode_a: mode_ff};
      mul_ctrl     = '{load: 1'b0, step: 1'b0};
      mem_we       = 1'b0;
      out_free     = !rsp_valid_ff || rsp_chan.ready;

      // Byte framing terms.
      gap_hit   = req_chan.gap_us > gap_lim_ff;
      pos0      = gap_hit ? '0 : pos_ff;
      recv0     = !gap_hit && recv_ff;
      start_hit = !recv0 && (pos0 == '0)
                  && (req_chan.byte_in == (mode_ff ? MODEA_START : MODEB_START));
      recv1     = recv0 || start_hit;
      exp1      = start_hit ? (mode_ff ? PW'(FRAME_BYTES) : PW'(MODEB_LEN)) : exp_ff;
      len_bad   = mode_ff && (pos0 == PW'(1))
                  && ({1'b0, req_chan.byte_in} > 9'(FRAME_BYTES - 3));
      exp2      = (mode_ff && (pos0 == PW'(1))) ? PW'(req_chan.byte_in) + PW'(3) : exp1;
      pos1      = {1'b0, pos0} + (PW+1)'(1);
      fend      = (pos1 >= {1'b0, exp2}) || (pos1 >= (PW+1)'(FRAME_BYTES));
      mem_waddr = pos0[AW-1:0];

      // Frame-end terms.
      crc_ok  = mode_ff ? (crc8 == lastb_ff) : (crc16 == {b25_ff, lastb_ff});
      len_m2  = len_ff - 8'd2;
      nbytes  = mode_ff ? 3'd4 : 3'd2;
      mem_raddr = AW'(base_ff + PW'(rd_cnt_ff));

      // Entry candidate terms.
      cand_num = word_ff[31:24];
      cand_fn  = word_ff[23:16];
      cand_ok  = !mode_ff || ((cand_num != 8'd0)
                 && ({1'b0, cand_num} <= 9'(MAX_CHANNELS)) && (cand_fn == 8'd0));
      cand_ch  = mode_ff ? CHANNEL_W'(cand_num - 8'd1) : ent_ff[CHANNEL_W-1:0];
      cand_pw  = PULSE_BASE + (mode_ff ? PULSE_W'(product[ACC_W-1:16])
                                       : product[ACC_W-1:12]);
      k_next   = k_ff + KW'(cand_ok);
      ent_done = (ent_ff + EW'(1) == n_ff) || (mode_ff && (k_next == KW'(MAX_CHANNELS)));

      case (state_ff)
         ST_IDLE: begin
            if (req_chan.valid) begin
               if (!recv1) begin
                  pos_in  = pos0;
                  recv_in = 1'b0;
               end else if (len_bad) begin
                  mem_we   = 1'b1;
                  pos_in   = '0;
                  recv_in  = 1'b0;
                  state_in = ST_BAD;
               end else begin
                  mem_we   = 1'b1;
                  exp_in   = exp2;
                  lastb_in = req_chan.byte_in;
                  if (pos0 == PW'(1)) len_in = req_chan.byte_in;
                  if (pos0 == PW'(2)) b2_in = req_chan.byte_in;
                  if (pos0 == PW'(3)) b3_in = req_chan.byte_in;
                  if (pos0 == PW'(MODEB_CRC_HI)) b25_in = req_chan.byte_in;
                  incl_in  = mode_ff ? (pos1 < {1'b0, exp2})
                                     : (pos1 + (PW+1)'(1) < {1'b0, exp2});
                  fend_in  = fend;
                  pos_in   = fend ? '0 : pos1[PW-1:0];
                  recv_in  = !fend;
                  crc_ctrl.load  = 1'b1;
                  crc_ctrl.clear = start_hit;
                  bit_cnt_in = '0;
                  state_in   = ST_CRC;
               end
            end
         end
         ST_CRC: begin
            crc_ctrl.shift = incl_ff;
            bit_cnt_in     = bit_cnt_ff + 3'd1;
            if (bit_cnt_ff == 3'd7) begin
               state_in = fend_ff ? ST_CHECK : ST_IDLE;
            end
         end
         ST_BAD: begin
            if (out_free) begin
               out_load      = 1'b1;
               rsp_status_in = STAT_BAD_LEN;
               rsp_ch_in     = '0;
               rsp_pw_in     = '0;
               rsp_last_in   = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         ST_CHECK: begin
            pend_v_in = 1'b0;
            k_in      = '0;
            ent_in    = '0;
            rd_cnt_in = '0;
            base_in   = mode_ff ? PW'(4) : PW'(1);
            if (mode_ff) begin
               n_in = (len_ff >= 8'd2) ? EW'(len_m2[7:2]) : '0;
            end else begin
               n_in = (chans_ff > 4'(MODEB_MAX_CH)) ? EW'(MODEB_MAX_CH) : EW'(chans_ff);
            end
            if (!crc_ok) begin
               if (out_free) begin
                  out_load      = 1'b1;
                  rsp_status_in = STAT_CRC_ERR;
                  rsp_ch_in     = '0;
                  rsp_pw_in     = '0;
                  rsp_last_in   = 1'b1;
                  state_in      = ST_IDLE;
               end
            end else if (mode_ff && (b2_ff == 8'd0) && (exp_ff > PW'(3))
                         && (b3_ff == FAILSAFE_HI)) begin
               if (out_free) begin
                  out_load      = 1'b1;
                  rsp_status_in = STAT_FAILSAFE;
                  rsp_ch_in     = '0;
                  rsp_pw_in     = '0;
                  rsp_last_in   = 1'b1;
                  state_in      = ST_IDLE;
               end
            end else begin
               state_in = (n_in == '0) ? ST_FLUSH : ST_READ;
            end
         end
         ST_READ: begin
            rd_cnt_in = rd_cnt_ff + 3'd1;
            if (rd_cnt_ff != 3'd0) begin
               word_in = {word_ff[23:0], mem_q_ff};
            end
            if (rd_cnt_ff == nbytes) begin
               mul_ctrl.load = 1'b1;
               mul_cnt_in    = '0;
               state_in      = ST_MUL;
            end
         end
         ST_MUL: begin
            mul_ctrl.step = 1'b1;
            mul_cnt_in    = mul_cnt_ff + 4'd1;
            if (mul_cnt_ff == 4'd15) begin
               state_in = ST_CAND;
            end
         end
         ST_CAND: begin
            if (!(cand_ok && pend_v_ff && !out_free)) begin
               if (cand_ok) begin
                  if (pend_v_ff) begin
                     out_load      = 1'b1;
                     rsp_status_in = STAT_UPDATE;
                     rsp_ch_in     = pend_ch_ff;
                     rsp_pw_in     = pend_pw_ff;
                     rsp_last_in   = 1'b0;
                  end
                  pend_v_in  = 1'b1;
                  pend_ch_in = cand_ch;
                  pend_pw_in = cand_pw;
               end
               k_in      = k_next;
               ent_in    = ent_ff + EW'(1);
               base_in   = base_ff + PW'(nbytes);
               rd_cnt_in = '0;
               state_in  = ent_done ? ST_FLUSH : ST_READ;
            end
         end
         ST_FLUSH: begin
            if (out_free) begin
               out_load      = 1'b1;
               rsp_status_in = pend_v_ff ? STAT_UPDATE : STAT_NO_UPD;
               rsp_ch_in     = pend_v_ff ? pend_ch_ff : '0;
               rsp_pw_in     = pend_v_ff ? pend_pw_ff : '0;
               rsp_last_in   = 1'b1;
               pend_v_in     = 1'b0;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // Configuration writes; a mode change restarts framing.
      if (csr_we) begin
         case (csr_index)
            CSR_MODE: begin
               mode_in = csr_wdata[0];
               pos_in  = '0;
               recv_in = 1'b0;
            end
            CSR_GAP: begin
               gap_lim_in = csr_wdata;
            end
            CSR_CHANS: begin
               chans_in = csr_wdata[3:0];
            end
            default: begin
            end
         endcase
      end

      // Output register holds until taken.
      if (out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         mode_ff      <= 1'b0;
         gap_lim_ff   <= GAP_LIMIT_RST;
         chans_ff     <= CHANS_RST;
         pos_ff       <= '0;
         exp_ff       <= PW'(MODEB_LEN);
         recv_ff      <= 1'b0;
         pend_v_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
         k_ff         <= '0;
      end else begin
         state_ff     <= state_in;
         mode_ff      <= mode_in;
         gap_lim_ff   <= gap_lim_in;
         chans_ff     <= chans_in;
         pos_ff       <= pos_in;
         exp_ff       <= exp_in;
         recv_ff      <= recv_in;
         pend_v_ff    <= pend_v_in;
         rsp_valid_ff <= rsp_valid_in;
         k_ff         <= k_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      b2_ff         <= b2_in;
      b3_ff         <= b3_in;
      b25_ff        <= b25_in;
      lastb_ff      <= lastb_in;
      len_ff        <= len_in;
      incl_ff       <= incl_in;
      fend_ff       <= fend_in;
      bit_cnt_ff    <= bit_cnt_in;
      n_ff          <= n_in;
      ent_ff        <= ent_in;
      base_ff       <= base_in;
      rd_cnt_ff     <= rd_cnt_in;
      word_ff       <= word_in;
      mul_cnt_ff    <= mul_cnt_in;
      pend_ch_ff    <= pend_ch_in;
      pend_pw_ff    <= pend_pw_in;
      rsp_status_ff <= rsp_status_in;
      rsp_ch_ff     <= rsp_ch_in;
      rsp_pw_ff     <= rsp_pw_in;
      rsp_last_ff   <= rsp_last_in;
   end

   // A held result never survives into byte collection.
   a_pend_clear: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_IDLE |-> !pend_v_ff)
      else $error("pending result left over in idle");

   // The update count never passes the channel limit.
   a_k_bound: assert property (@(posedge clock) disable iff (reset)
      k_ff <= KW'(MAX_CHANNELS))
      else $error("update count over limit");

   // The final result of a frame returns the sequencer to byte collection.
   a_last_idle: assert property (@(posedge clock) disable iff (reset)
      (out_load && rsp_last_in) |=> state_ff == ST_IDLE)
      else $error("sequencer busy after final result");

   // While inside a frame the byte position is never zero.
   a_recv_pos: assert property (@(posedge clock) disable iff (reset)
      recv_ff |-> pos_ff != '0)
      else $error("receiving with zero position");
endmodule

### sim/rc_serial_frame_decoder_tb.sv
// Self-checking testbench of the serial RC frame decoder: predicted results versus the result channel.
`timescale 1ns / 1ps
module rc_serial_frame_decoder_tb;
   import rcfd_pkg::*;

   typedef struct packed {
      logic [7:0]  byte_in;
      logic [15:0] gap_us;
   } rx_byte_t;

   typedef struct packed {
      logic [STATUS_W-1:0]  status;
      logic [CHANNEL_W-1:0] channel;
      logic [PULSE_W-1:0]   pulse_us;
      logic                 last;
   } frame_result_t;

   localparam int FB = FRAME_BYTES_DEF;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic                  csr_we = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = CSR_MODE;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   rcfd_req_if req_chan ();
   rcfd_rsp_if rsp_chan ();

   rc_serial_frame_decoder u_dut (
      .clock(clock), .reset(reset), .req_chan(req_chan.sink), .rsp_chan(rsp_chan.source),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always #10 clock = ~clock;

   // Predictor state and configuration copy.
   logic        cfg_mode_a;
   logic [15:0] cfg_gap_limit;
   logic [3:0]  cfg_chans;
   logic [7:0]  rx_frame [FB];
   int          rx_pos;
   int          rx_len;
   logic        rx_busy;

   rx_byte_t      byte_queue [$];
   frame_result_t expected_results [$];
   int  error_count = 0;
   int  result_count = 0;
   int  frame_count = 0;
   logic quiet = 1'b0;      // no idling in the final part of the run
   logic hold_req = 1'b0;   // asks for one long receiver hold-off
   logic hold_used;
   int  hold_cycles;

   function automatic logic [7:0] frame_byte(int i);
      return (i < FB) ? rx_frame[i] : 8'h00;
   endfunction

   function automatic logic [15:0] frame_crc16(int n);
      logic [15:0] c;
      c = 16'h0000;
      for (int i = 0; i < n; i++) begin
         c = c ^ {frame_byte(i), 8'h00};
         for (int b = 0; b < 8; b++) begin
            c = c[15] ? ((c << 1) ^ CRC16_POLY) : (c << 1);
         end
      end
      return c;
   endfunction

   function automatic logic [7:0] frame_crc8(int n);
      logic [7:0] c, d;
      logic mix;
      c = 8'h00;
      for (int i = 0; i < n; i++) begin
         d = frame_byte(i);
         for (int b = 0; b < 8; b++) begin
            mix = c[0] ^ d[0];
            c = c >> 1;
            if (mix) begin
               c = c ^ CRC8_POLY;
            end
            d = d >> 1;
         end
      end
      return c;
   endfunction

   function automatic void push_result(logic [2:0] st, logic [3:0] ch, logic [14:0] pw,
                                       logic lst);
      frame_result_t r;
      r.status = st; r.channel = ch; r.pulse_us = pw; r.last = lst;
      expected_results.push_back(r);
   endfunction

   // Unpack a finished frame into expected results.
   function automatic void decode_frame();
      frame_result_t rs [$];
      frame_result_t r;
      int n, len;
      logic [31:0] v;
      logic [7:0] b3;
      r = '0;
      if (!cfg_mode_a) begin
         n = (cfg_chans > MODEB_MAX_CH) ? MODEB_MAX_CH : int'(cfg_chans);
         if (frame_crc16(25) != {frame_byte(25), frame_byte(26)}) begin
            r.status = STAT_CRC_ERR; rs.push_back(r);
         end else begin
            for (int i = 0; i < n; i++) begin
               v = 32'({frame_byte(1 + 2 * i), frame_byte(2 + 2 * i)});
               r.status = STAT_UPDATE; r.channel = CHANNEL_W'(i);
               r.pulse_us = PULSE_W'(32'd800 + ((v * 32'd1400) >> 12));
               rs.push_back(r);
            end
         end
      end else begin
         len = int'(frame_byte(1));
         b3 = (rx_len > 3) ? frame_byte(3) : 8'h00;
         n = (len >= 2) ? (len - 2) / 4 : 0;
         if (frame_crc8(len + 2) != frame_byte(len + 2)) begin
            r.status = STAT_CRC_ERR; rs.push_back(r);
         end else if (frame_byte(2) == 8'h00 && b3 == FAILSAFE_HI) begin
            r.status = STAT_FAILSAFE; rs.push_back(r);
         end else begin
            for (int i = 0; i < n && rs.size() < MAX_CHANNELS_DEF; i++) begin
               v = 32'({frame_byte(6 + 4 * i), frame_byte(7 + 4 * i)});
               if (frame_byte(4 + 4 * i) >= 1 && frame_byte(4 + 4 * i) <= MAX_CHANNELS_DEF
                   && frame_byte(5 + 4 * i) == 0) begin
                  r.status = STAT_UPDATE;
                  r.channel = CHANNEL_W'(frame_byte(4 + 4 * i) - 8'd1);
                  r.pulse_us = PULSE_W'(32'd800 + ((v * 32'd1400) >> 16));
                  rs.push_back(r);
               end
            end
         end
      end
      if (rs.size() == 0) begin
         r = '0; r.status = STAT_NO_UPD; rs.push_back(r);
      end
      rs[rs.size() - 1].last = 1'b1;
      foreach (rs[i]) expected_results.push_back(rs[i]);
      frame_count++;
   endfunction

   // Predict the effect of one accepted byte.
   function automatic void predict_byte(rx_byte_t it);
      if (it.gap_us > cfg_gap_limit) begin
         rx_pos = 0; rx_busy = 0;
      end
      if (rx_pos == 0 && !rx_busy) begin
         if (!cfg_mode_a && it.byte_in == MODEB_START) begin
            rx_busy = 1; rx_len = MODEB_LEN;
         end else if (cfg_mode_a && it.byte_in == MODEA_START) begin
            rx_busy = 1; rx_len = FB;
         end
      end
      if (!rx_busy) begin
         return;
      end
      if (rx_pos < FB) begin
         rx_frame[rx_pos] = it.byte_in;
      end
      if (cfg_mode_a && rx_pos == 1) begin
         if (it.byte_in > FB - 3) begin
            push_result(STAT_BAD_LEN, 4'd0, 15'd0, 1'b1);
            frame_count++;
            rx_pos = 0; rx_busy = 0;
            return;
         end
         rx_len = int'(it.byte_in) + 3;
      end
      rx_pos++;
      if (rx_pos < rx_len && rx_pos < FB) begin
         return;
      end
      decode_frame();
      rx_pos = 0; rx_busy = 0;
   endfunction

   // Track a configuration write; a mode change restarts framing.
   function automatic void apply_csr(logic [CSR_IDX_W-1:0] idx, logic [15:0] val);
      if (idx == CSR_MODE) begin
         cfg_mode_a = val[0]; rx_pos = 0; rx_busy = 0;
      end else if (idx == CSR_GAP) begin
         cfg_gap_limit = val;
      end else if (idx == CSR_CHANS) begin
         cfg_chans = val[3:0];
      end
   endfunction

   // Driver: offers queued items with random gaps.
   int send_gap = 0;
   always @(posedge clock) begin
      if (reset) begin
         req_chan.valid   <= 1'b0;
         req_chan.byte_in <= 8'h00;
         req_chan.gap_us  <= 16'h0000;
         cfg_mode_a = 0; cfg_gap_limit = GAP_LIMIT_RST; cfg_chans = CHANS_RST;
         rx_pos = 0; rx_len = MODEB_LEN; rx_busy = 0;
      end else begin
         if (csr_we) begin
            apply_csr(csr_index, csr_wdata);
         end
         if (req_chan.valid && req_chan.ready) begin
            predict_byte({req_chan.byte_in, req_chan.gap_us});
         end
         if (!req_chan.valid || req_chan.ready) begin
            if (send_gap > 0) begin
               send_gap <= send_gap - 1;
               req_chan.valid <= 1'b0;
            end else if (byte_queue.size() > 0) begin
               rx_byte_t nx;
               nx = byte_queue.pop_front();
               req_chan.valid <= 1'b1;
               req_chan.byte_in <= nx.byte_in;
               req_chan.gap_us <= nx.gap_us;
               if (!quiet && $urandom_range(0, 7) == 0) begin
                  send_gap <= $urandom_range(1, 16);
               end
            end else begin
               req_chan.valid <= 1'b0;
            end
         end
      end
   end

   // Long receiver hold-off, counted in cycles.
   always @(posedge clock) begin
      if (reset) begin
         hold_cycles <= 0;
         hold_used   <= 1'b0;
      end else if (hold_req && !hold_used) begin
         hold_cycles <= 3000;
         hold_used   <= 1'b1;
      end else if (hold_cycles > 0) begin
         hold_cycles <= hold_cycles - 1;
      end
   end

   // Monitor: checks each accepted result and applies receiver stalls.
   int stall = 0;
   always @(posedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            frame_result_t got, exp;
            got = {rsp_chan.status, rsp_chan.channel, rsp_chan.pulse_us, rsp_chan.last};
            result_count++;
            if (expected_results.size() == 0) begin
               error_count++;
               $display("%0t: unexpected result %h", $time, got);
            end else begin
               exp = expected_results.pop_front();
               if (got.status !== exp.status)
                  $display("%0t: status expected %0d actual %0d", $time, exp.status,
                           got.status);
               if (got.channel !== exp.channel)
                  $display("%0t: channel expected %0d actual %0d", $time, exp.channel,
                           got.channel);
               if (got.pulse_us !== exp.pulse_us)
                  $display("%0t: pulse_us expected %0d actual %0d", $time, exp.pulse_us,
                           got.pulse_us);
               if (got.last !== exp.last)
                  $display("%0t: last expected %0d actual %0d", $time, exp.last, got.last);
               if (got !== exp) begin
                  error_count++;
               end
            end
         end
         if (hold_cycles > 0) begin
            rsp_chan.ready <= 1'b0;
         end else if (stall > 0) begin
            stall <= stall - 1;
            rsp_chan.ready <= 1'b0;
         end else if (!quiet && $urandom_range(0, 7) == 0) begin
            stall <= $urandom_range(1, 16);
            rsp_chan.ready <= 1'b0;
         end else begin
            rsp_chan.ready <= 1'b1;
         end
      end
   end

   // Stimulus helpers.
   task automatic add_byte(logic [7:0] b, logic [15:0] g);
      byte_queue.push_back({b, g});
   endtask

   function automatic logic [15:0] short_gap();
      return 16'($urandom_range(0, 200));
   endfunction

   task automatic add_frame_b(bit good_crc);
      logic [7:0] f [27];
      logic [15:0] c;
      f[0] = MODEB_START;
      for (int i = 1; i < 25; i++) f[i] = 8'($urandom_range(0, 255));
      c = 16'h0000;
      for (int i = 0; i < 25; i++) begin
         c = c ^ {f[i], 8'h00};
         for (int b = 0; b < 8; b++) c = c[15] ? ((c << 1) ^ CRC16_POLY) : (c << 1);
      end
      if (!good_crc) c = c ^ (16'h1 << $urandom_range(0, 15));
      f[25] = c[15:8]; f[26] = c[7:0];
      foreach (f[i]) add_byte(f[i], short_gap());
   endtask

   task automatic add_frame_a(int len, int kind, bit good_crc);
      logic [7:0] f [$];
      logic [7:0] c, d;
      logic mix;
      f.push_back(MODEA_START);
      f.push_back(8'(len));
      for (int i = 2; i < len + 2; i++) begin
         if (i >= 4 && (i % 4) == 0 && kind != 2)
            f.push_back(8'($urandom_range(0, 3) == 0 ? $urandom_range(0, 255)
                                                     : $urandom_range(1, 16)));
         else if (i >= 4 && (i % 4) == 1 && kind != 2)
            f.push_back($urandom_range(0, 5) == 0 ? 8'($urandom_range(1, 255)) : 8'h00);
         else
            f.push_back(8'($urandom_range(0, 255)));
      end
      if (kind == 1 && len >= 2) begin
         f[2] = 8'h00; f[3] = FAILSAFE_HI;
      end else if (len >= 2 && f[2] == 8'h00 && f[3] == FAILSAFE_HI) begin
         f[2] = 8'h01;
      end
      c = 8'h00;
      foreach (f[i]) begin
         d = f[i];
         for (int b = 0; b < 8; b++) begin
            mix = c[0] ^ d[0]; c = c >> 1;
            if (mix) c = c ^ CRC8_POLY;
            d = d >> 1;
         end
      end
      if (!good_crc) c = c ^ (8'h1 << $urandom_range(0, 7));
      f.push_back(c);
      foreach (f[i]) add_byte(f[i], short_gap());
   endtask

   task automatic wait_drained();
      while (byte_queue.size() > 0 || req_chan.valid || expected_results.size() > 0)
         @(posedge clock);
      repeat (400) @(posedge clock);
   endtask

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [15:0] val);
      @(posedge clock);
      csr_we <= 1'b1; csr_index <= idx; csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic random_phase(int n_items);
      int start;
      start = byte_queue.size();
      while (byte_queue.size() - start < n_items) begin
         case ($urandom_range(0, 9))
            0: add_byte(8'($urandom_range(0, 255)), 16'($urandom_range(0, 65535)));
            1: add_byte(cfg_mode_a ? MODEB_START : MODEA_START, short_gap());
            2: begin
               // Broken frame: start then a long gap restarts framing.
               add_byte(cfg_mode_a ? MODEA_START : MODEB_START, short_gap());
               add_byte(8'($urandom_range(0, 255)), short_gap());
               add_byte(8'h00, 16'hFFFF);
            end
            default: begin
               if (cfg_mode_a)
                  add_frame_a($urandom_range(0, 3) == 0 ? $urandom_range(0, 66)
                                                        : $urandom_range(2, 30),
                              $urandom_range(0, 9) == 0, $urandom_range(0, 5) != 0);
               else
                  add_frame_b($urandom_range(0, 5) != 0);
            end
         endcase
      end
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Directed mode B: reset settings, noise, good and bad checks, other channel and gap limits.
      add_byte(8'h00, 16'h0000);
      add_byte(8'hFF, 16'hFFFF);
      add_frame_b(1);
      add_frame_b(0);
      wait_drained();
      write_reg(CSR_CHANS, 16'd0);
      add_frame_b(1);
      wait_drained();
      write_reg(CSR_CHANS, 16'd15);
      write_reg(CSR_GAP, 16'd0);
      add_frame_b(1);
      add_byte(MODEB_START, 16'd0);
      add_byte(8'h55, 16'd1);
      wait_drained();

      // Directed: mode A lengths, failsafe, bad check and bad length.
      write_reg(CSR_GAP, 16'hFFFF);
      write_reg(CSR_MODE, 16'd1);
      add_frame_a(0, 0, 1);
      add_frame_a(1, 0, 1);
      add_frame_a(6, 1, 1);
      add_frame_a(66, 0, 1);
      add_frame_a(10, 0, 0);
      add_byte(MODEA_START, 16'd5);
      add_byte(8'd67, 16'd5);
      add_byte(MODEA_START, 16'd5);
      add_byte(8'hFF, 16'd5);
      wait_drained();

      // Random mode A with a long receiver hold-off.
      write_reg(CSR_GAP, 16'd150);
      hold_req = 1'b1;
      random_phase(25);
      wait_drained();

      // Random mode B with a reduced channel count, then with twelve channels.
      write_reg(CSR_MODE, 16'd0);
      write_reg(CSR_CHANS, 16'd1);
      write_reg(CSR_GAP, 16'd8000);
      random_phase(10);
      wait_drained();
      write_reg(CSR_CHANS, 16'd12);
      random_phase(10);
      wait_drained();

      // Final part without idling.
      write_reg(CSR_MODE, 16'd1);
      quiet = 1'b1;
      random_phase(15);
      wait_drained();

      $display("Covered %0d frame outcomes and %0d results in both modes,", frame_count,
               result_count);
      $display("with gap restarts, check errors, failsafe, bad lengths and stalls.");
      if (error_count == 0) begin
         $display("rc_serial_frame_decoder_tb: done, clean");
      end else begin
         $display("rc_serial_frame_decoder_tb: done, errors");
      end
      $finish;
   end

   // Run limit.
   initial begin
      #50ms;
      $display("rc_serial_frame_decoder_tb: done, errors");
      $finish;
   end
endmodule

### filelist.f
hdl/rcfd_pkg.sv
hdl/rcfd_req_if.sv
hdl/rcfd_rsp_if.sv
hdl/rcfd_crc_serial.sv
hdl/rcfd_mul_serial.sv
hdl/rc_serial_frame_decoder.sv
sim/rc_serial_frame_decoder_tb.sv
